@@ design/cht_pkg.sv @@
// cht_pkg: shared types, field widths, mode and status codes for the
// canonical huffman code table core; no dependencies
package cht_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int SYMBOL_BITS  = 8;

    localparam int MODE_W = 3;
    localparam int LEN_W  = 5;
    localparam int CNT_W  = 9;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 3'd0,
        MODE_LOAD  = 3'd1,
        MODE_ADD   = 3'd2,
        MODE_ENC   = 3'd3,
        MODE_DEC   = 3'd4
    } t_mode;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_TOO_MANY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  length;
        logic [CNT_W-1:0]  count;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [LEN_W-1:0]  length_out;
        logic [SYM_W-1:0]  symbol_out;
        logic              found;
        logic [STAT_W-1:0] status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ADD,
        ST_READ
    } t_state;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic exec;
        logic add_commit;
        logic read_done;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_busy;
        logic              clr_last;
    } t_dp_status;

endpackage

@@ design/cht_ram.sv @@
// cht_ram: generic single write port, single read port ram with registered read
// no dependencies
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/cht_ctrl.sv @@
// cht_ctrl: sequencer for the code table core, issues datapath commands
// depends on cht_pkg
module cht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cht_pkg::t_dp_status i_status,
    output cht_pkg::t_dp_cmd    o_cmd
);

    cht_pkg::t_state r_state;
    cht_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cht_pkg::ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = cht_pkg::ST_IDLE;
                end
            end
            cht_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = cht_pkg::ST_EXEC;
                end
            end
            cht_pkg::ST_EXEC: begin
                if (!i_status.out_busy) begin
                    unique case (i_status.mode)
                        cht_pkg::MODE_CLEAR: n_state = cht_pkg::ST_CLEAR;
                        cht_pkg::MODE_ADD:   n_state = cht_pkg::ST_ADD;
                        cht_pkg::MODE_ENC:   n_state = cht_pkg::ST_READ;
                        cht_pkg::MODE_DEC:   n_state = cht_pkg::ST_READ;
                        default:             n_state = cht_pkg::ST_IDLE;
                    endcase
                end
            end
            cht_pkg::ST_ADD, cht_pkg::ST_READ: begin
                if (!i_status.out_busy) begin
                    n_state = cht_pkg::ST_IDLE;
                end
            end
            default: n_state = cht_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            cht_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            cht_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            cht_pkg::ST_EXEC: begin
                o_cmd.exec = !i_status.out_busy;
            end
            cht_pkg::ST_ADD: begin
                o_cmd.add_commit = !i_status.out_busy;
            end
            cht_pkg::ST_READ: begin
                o_cmd.read_done = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ design/cht_dp.sv @@
// cht_dp: code table datapath, per-length registers, symbol and code rams,
// output register; depends on cht_pkg and cht_ram
module cht_dp #(
    parameter int MAX_CODE_LEN = cht_pkg::MAX_CODE_LEN,
    parameter int SYMBOL_BITS  = cht_pkg::SYMBOL_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cht_pkg::t_dp_cmd    i_cmd,
    output cht_pkg::t_dp_status o_status,
    input  cht_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cht_pkg::t_out_item  o_out_data
);

    localparam int NSYM = 1 << SYMBOL_BITS;
    localparam int SB   = SYMBOL_BITS;
    localparam int AW   = SYMBOL_BITS + 1;
    localparam int CW   = MAX_CODE_LEN;
    localparam int NCW  = MAX_CODE_LEN + 1;
    localparam int LW   = $clog2(MAX_CODE_LEN + 1);
    localparam int IW   = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int DW   = (CW > cht_pkg::CODE_W) ? CW : cht_pkg::CODE_W;
    localparam int NW   = (AW > cht_pkg::CNT_W) ? AW : cht_pkg::CNT_W;
    localparam int MW   = (DW > NW) ? DW : NW;

    cht_pkg::t_in_item  r_in;
    cht_pkg::t_out_item r_out;
    cht_pkg::t_out_item n_out;
    logic               r_out_valid;

    logic [cht_pkg::CNT_W-1:0] r_cnt        [MAX_CODE_LEN];
    logic [CW-1:0]             r_first_code [MAX_CODE_LEN];
    logic [SB-1:0]             r_first_idx  [MAX_CODE_LEN];
    logic [NCW-1:0]            r_next_code;
    logic [LW-1:0]             r_cur_len;
    logic [AW-1:0]             r_assigned;
    logic [cht_pkg::CNT_W-1:0] r_remain;
    logic [SB-1:0]             r_clr_addr;

    logic [LW-1:0]             r_add_len;
    logic [cht_pkg::CNT_W-1:0] r_add_rem;
    logic                      r_add_new;
    logic                      r_add_fail;
    logic                      r_dec_hit;

    logic [IW-1:0]             len_idx;
    logic [SB-1:0]             sym_idx;
    logic                      in_len_ok;
    logic                      mode_clear;
    logic                      mode_load;
    logic                      mode_add;
    logic                      mode_enc;
    logic                      mode_dec;

    logic                      srch_found;
    logic [IW-1:0]             srch_idx;
    logic [LW-1:0]             srch_len;
    logic                      n_add_fail;
    logic                      n_add_new;
    logic [LW-1:0]             n_add_len;
    logic [cht_pkg::CNT_W-1:0] n_add_rem;

    logic [NCW-1:0]            add_code;
    logic [NCW-1:0]            add_limit;
    logic                      add_ovf;
    logic                      add_ok;
    logic [IW-1:0]             add_slot;

    logic [CW-1:0]             dec_first;
    logic [SB-1:0]             dec_fidx;
    logic [NW-1:0]             dec_n;
    logic                      dec_len_ok;
    logic [DW:0]               dec_diff;
    logic                      dec_hit;
    logic [SB-1:0]             dec_idx;

    logic                      emit;
    logic                      sym_wr_en;
    logic [SB-1:0]             sym_rd;
    logic                      code_wr_en;
    logic [SB-1:0]             code_wr_addr;
    logic [CW+LW-1:0]          code_wr_data;
    logic [CW+LW-1:0]          code_rd;

    assign mode_clear = (r_in.mode == cht_pkg::MODE_CLEAR);
    assign mode_load  = (r_in.mode == cht_pkg::MODE_LOAD);
    assign mode_add   = (r_in.mode == cht_pkg::MODE_ADD);
    assign mode_enc   = (r_in.mode == cht_pkg::MODE_ENC);
    assign mode_dec   = (r_in.mode == cht_pkg::MODE_DEC);

    assign len_idx   = IW'(r_in.length - 5'd1);
    assign sym_idx   = SB'(r_in.symbol);
    assign in_len_ok = (r_in.length != '0) && (32'(r_in.length) <= 32'(MAX_CODE_LEN));

    // lowest length above the current one that still has codes
    always_comb begin
        srch_found = 1'b0;
        srch_idx   = '0;
        srch_len   = '0;
        for (int i = MAX_CODE_LEN - 1; i >= 0; i--) begin
            if (r_cnt[i] != '0 && i >= int'(r_cur_len)) begin
                srch_found = 1'b1;
                srch_idx   = IW'(i);
                srch_len   = LW'(i + 1);
            end
        end
    end

    assign n_add_new  = (r_remain == '0);
    assign n_add_fail = r_assigned[SB] || (n_add_new && !srch_found);
    assign n_add_len  = n_add_new ? srch_len : r_cur_len;
    assign n_add_rem  = n_add_new ? r_cnt[srch_idx] : r_remain;

    // zeros appended when the length grows
    assign add_code  = r_add_new ? (r_next_code << (r_add_len - r_cur_len)) : r_next_code;
    assign add_limit = NCW'(1) << r_add_len;
    assign add_ovf   = (add_code >= add_limit);
    assign add_ok    = !r_add_fail && !add_ovf;
    assign add_slot  = IW'(r_add_len - LW'(1));

    assign dec_first  = r_first_code[len_idx];
    assign dec_fidx   = r_first_idx[len_idx];
    assign dec_len_ok = in_len_ok && (32'(r_in.length) <= 32'(r_cur_len));
    // the length being filled only counts what has been assigned so far
    assign dec_n      = (32'(r_in.length) == 32'(r_cur_len))
                        ? NW'(r_assigned - AW'(dec_fidx))
                        : NW'(r_cnt[len_idx]);
    assign dec_diff   = {1'b0, DW'(r_in.code)} - {1'b0, DW'(dec_first)};
    assign dec_hit    = dec_len_ok && !dec_diff[DW]
                        && (MW'(dec_diff[DW-1:0]) < MW'(dec_n));
    assign dec_idx    = dec_fidx + SB'(dec_diff[DW-1:0]);

    assign sym_wr_en    = i_cmd.add_commit && add_ok;
    assign code_wr_en   = i_cmd.clr_step || sym_wr_en;
    assign code_wr_addr = i_cmd.clr_step ? r_clr_addr : sym_idx;
    assign code_wr_data = i_cmd.clr_step ? '0 : {CW'(add_code), r_add_len};

    cht_ram #(
        .WIDTH (SB),
        .DEPTH (NSYM)
    ) u_sym_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sym_wr_en),
        .i_wr_addr (SB'(r_assigned)),
        .i_wr_data (sym_idx),
        .i_rd_en   (i_cmd.exec && mode_dec),
        .i_rd_addr (dec_idx),
        .o_rd_data (sym_rd)
    );

    cht_ram #(
        .WIDTH (CW + LW),
        .DEPTH (NSYM)
    ) u_code_ram (
        .i_clk     (i_clk),
        .i_wr_en   (code_wr_en),
        .i_wr_addr (code_wr_addr),
        .i_wr_data (code_wr_data),
        .i_rd_en   (i_cmd.exec && mode_enc),
        .i_rd_addr (sym_idx),
        .o_rd_data (code_rd)
    );

    // result beat
    always_comb begin
        emit  = (i_cmd.exec && !(mode_add || mode_enc || mode_dec))
                || i_cmd.add_commit || i_cmd.read_done;
        n_out = '0;
        n_out.status = cht_pkg::STATUS_OK;
        if (i_cmd.add_commit) begin
            if (r_add_fail) begin
                n_out.status = cht_pkg::STATUS_TOO_MANY;
            end else if (add_ovf) begin
                n_out.status = cht_pkg::STATUS_OVERFLOW;
            end else begin
                n_out.code_out   = cht_pkg::CODE_W'(add_code);
                n_out.length_out = cht_pkg::LEN_W'(r_add_len);
            end
        end else if (i_cmd.read_done) begin
            if (mode_enc) begin
                if (code_rd[LW-1:0] != '0) begin
                    n_out.code_out   = cht_pkg::CODE_W'(code_rd[CW+LW-1:LW]);
                    n_out.length_out = cht_pkg::LEN_W'(code_rd[LW-1:0]);
                    n_out.found      = 1'b1;
                end
            end else if (r_dec_hit) begin
                n_out.code_out   = r_in.code;
                n_out.length_out = r_in.length;
                n_out.symbol_out = cht_pkg::SYM_W'(sym_rd);
                n_out.found      = 1'b1;
            end
        end
    end

    // table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
                r_cnt[i]        <= '0;
                r_first_code[i] <= '0;
                r_first_idx[i]  <= '0;
            end
            r_next_code <= '0;
            r_cur_len   <= '0;
            r_assigned  <= '0;
            r_remain    <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.exec && mode_clear) begin
                for (int i = 0; i < MAX_CODE_LEN; i++) begin
                    r_cnt[i]        <= '0;
                    r_first_code[i] <= '0;
                    r_first_idx[i]  <= '0;
                end
                r_next_code <= '0;
                r_cur_len   <= '0;
                r_assigned  <= '0;
                r_remain    <= '0;
                r_clr_addr  <= '0;
            end
            // counts freeze once any symbol is assigned
            if (i_cmd.exec && mode_load && in_len_ok && r_assigned == '0) begin
                r_cnt[len_idx] <= r_in.count;
            end
            if (sym_wr_en) begin
                if (r_add_new) begin
                    r_first_code[add_slot] <= CW'(add_code);
                    r_first_idx[add_slot]  <= SB'(r_assigned);
                    r_cur_len              <= r_add_len;
                end
                r_assigned  <= r_assigned + 1'b1;
                r_remain    <= r_add_rem - 1'b1;
                r_next_code <= add_code + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and per-item scratch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_add_fail <= n_add_fail;
            r_add_new  <= n_add_new;
            r_add_len  <= n_add_len;
            r_add_rem  <= n_add_rem;
            r_dec_hit  <= dec_hit;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_status.mode     = r_in.mode;
    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_status.clr_last = (r_clr_addr == '1);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/canonical_huffman_code_table_core.sv @@
// canonical_huffman_code_table_core: top level of the canonical huffman code table
// depends on cht_pkg, cht_ctrl, cht_dp, cht_ram
//
//   port group    dir  handshake                    beat
//   item in       in   i_in_valid / o_in_stall      i_in_data  (cht_pkg::t_in_item)
//   result out    out  o_out_valid / i_out_stall    o_out_data (cht_pkg::t_out_item)
//
// clear, load and unused modes pass each beat through accept and execute
// add symbol, encode and decode pass through accept, execute or ram read, then finish
// after reset and after every clear beat every entry of the code ram is swept,
// with o_in_stall high; the per-length registers clear at once
// a result waits in the output register while the next beat is accepted; that
// beat holds in execute until the output register frees
module canonical_huffman_code_table_core #(
    parameter int MAX_CODE_LEN = cht_pkg::MAX_CODE_LEN,
    parameter int SYMBOL_BITS  = cht_pkg::SYMBOL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cht_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cht_pkg::t_out_item o_out_data
);

    cht_pkg::t_dp_cmd    w_cmd;
    cht_pkg::t_dp_status w_status;

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cht_dp #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for canonical_huffman_code_table_core
// depends on cht_pkg and the core; holds its own model of the code table
// and drives directed beats, random table builds, lookups and noise beats through it
module tb;

    localparam int MAX_CODE_LEN = cht_pkg::MAX_CODE_LEN;
    localparam int SYMBOL_BITS  = cht_pkg::SYMBOL_BITS;
    localparam int MODE_W       = cht_pkg::MODE_W;
    localparam int LEN_W        = cht_pkg::LEN_W;
    localparam int CNT_W        = cht_pkg::CNT_W;
    localparam int SYM_W        = cht_pkg::SYM_W;
    localparam int CODE_W       = cht_pkg::CODE_W;

    localparam int NSYM         = 1 << SYMBOL_BITS;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 16;
    localparam int HOLD_CYCLES  = 400;

    class huff_table_checker;
        bit [CNT_W-1:0]     len_count [MAX_CODE_LEN];
        bit [63:0]          first_code [MAX_CODE_LEN];
        int unsigned        first_index [MAX_CODE_LEN];
        bit [SYM_W-1:0]     sym_at_index [NSYM];
        bit [63:0]          code_of [NSYM];
        int unsigned        len_of [NSYM];
        bit [63:0]          run_code;
        int unsigned        cur_len;
        int unsigned        n_assigned;
        int unsigned        left_in_len;
        cht_pkg::t_out_item pending_results [$];

        function new();
            clear_table();
        endfunction

        function void clear_table();
            for (int l = 0; l < MAX_CODE_LEN; l++) begin
                len_count[l]   = '0;
                first_code[l]  = '0;
                first_index[l] = 0;
            end
            for (int s = 0; s < NSYM; s++) begin
                sym_at_index[s] = '0;
                code_of[s]      = '0;
                len_of[s]       = 0;
            end
            run_code    = '0;
            cur_len     = 0;
            n_assigned  = 0;
            left_in_len = 0;
        endfunction

        // next canonical code: widen to the next length that still has codes
        function cht_pkg::t_out_item assign_code(bit [SYM_W-1:0] sym);
            cht_pkg::t_out_item r;
            bit [63:0]          c;
            int unsigned        ln;
            int unsigned        rem;
            int unsigned        l;
            bit                 newlen;
            r      = '0;
            c      = run_code;
            ln     = cur_len;
            rem    = left_in_len;
            newlen = 1'b0;
            if (n_assigned >= NSYM) begin
                r.status = cht_pkg::STATUS_TOO_MANY;
                return r;
            end
            if (rem == 0) begin
                l = cur_len + 1;
                while (l <= MAX_CODE_LEN && len_count[l-1] == 0)
                    l++;
                if (l > MAX_CODE_LEN) begin
                    r.status = cht_pkg::STATUS_TOO_MANY;
                    return r;
                end
                c      = run_code << (l - cur_len);
                ln     = l;
                rem    = int'(len_count[l-1]);
                newlen = 1'b1;
            end
            if (c >= (64'd1 << ln)) begin
                r.status = cht_pkg::STATUS_OVERFLOW;
                return r;
            end
            if (newlen) begin
                first_code[ln-1]  = c;
                first_index[ln-1] = n_assigned;
                cur_len           = ln;
            end
            sym_at_index[n_assigned % NSYM] = sym;
            code_of[sym] = c;
            len_of[sym]  = ln;
            n_assigned++;
            left_in_len  = rem - 1;
            run_code     = c + 1;
            r.code_out   = c[CODE_W-1:0];
            r.length_out = LEN_W'(ln);
            return r;
        endfunction

        function cht_pkg::t_out_item decode_code(int unsigned len, bit [CODE_W-1:0] code);
            cht_pkg::t_out_item r;
            int unsigned        n;
            int unsigned        idx;
            bit [63:0]          first;
            bit [63:0]          c;
            r = '0;
            c = 64'(code);
            if (len == 0 || len > MAX_CODE_LEN || len > cur_len)
                return r;
            if (len == cur_len)
                n = n_assigned - first_index[len-1];
            else
                n = int'(len_count[len-1]);
            first = first_code[len-1];
            if (n != 0 && c >= first && c - first < 64'(n)) begin
                idx          = first_index[len-1] + int'(c - first);
                r.code_out   = code;
                r.length_out = LEN_W'(len);
                r.symbol_out = sym_at_index[idx % NSYM];
                r.found      = 1'b1;
            end
            return r;
        endfunction

        function cht_pkg::t_out_item table_result(cht_pkg::t_in_item beat);
            cht_pkg::t_out_item r;
            r = '0;
            case (beat.mode)
                cht_pkg::MODE_CLEAR: clear_table();
                cht_pkg::MODE_LOAD: begin
                    if (beat.length >= 1 && beat.length <= MAX_CODE_LEN && n_assigned == 0)
                        len_count[beat.length-1] = beat.count;
                end
                cht_pkg::MODE_ADD: r = assign_code(beat.symbol);
                cht_pkg::MODE_ENC: begin
                    if (len_of[beat.symbol] != 0) begin
                        r.code_out   = code_of[beat.symbol][CODE_W-1:0];
                        r.length_out = LEN_W'(len_of[beat.symbol]);
                        r.found      = 1'b1;
                    end
                end
                cht_pkg::MODE_DEC: r = decode_code(int'(beat.length), beat.code);
                default: ;
            endcase
            return r;
        endfunction

        function void note_beat(cht_pkg::t_in_item beat);
            pending_results = {pending_results, table_result(beat)};
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // empty string when the beat matches the oldest expected result
        function string check_beat(cht_pkg::t_out_item got);
            cht_pkg::t_out_item want;
            string              why;
            if (pending_results.size() == 0)
                return $sformatf("result beat %h with nothing expected", got);
            want = pending_results.pop_front();
            why  = "";
            if (got.code_out !== want.code_out)
                why = {why, $sformatf(" code_out %h/%h", got.code_out, want.code_out)};
            if (got.length_out !== want.length_out)
                why = {why, $sformatf(" length_out %0d/%0d", got.length_out, want.length_out)};
            if (got.symbol_out !== want.symbol_out)
                why = {why, $sformatf(" symbol_out %h/%h", got.symbol_out, want.symbol_out)};
            if (got.found !== want.found)
                why = {why, $sformatf(" found %b/%b", got.found, want.found)};
            if (got.status !== want.status)
                why = {why, $sformatf(" status %0d/%0d", got.status, want.status)};
            if (why != "")
                why = {"result mismatch, got/expected:", why};
            return why;
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    cht_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    cht_pkg::t_out_item out_data;

    huff_table_checker sb;
    int n_accepted = 0;
    int n_errors   = 0;
    int n_cycles   = 0;
    int burst_left = 0;

    // current table profile, used to aim decode lookups at real codes
    int      prof_count [MAX_CODE_LEN];
    longint  prof_first [MAX_CODE_LEN];
    int      seen_syms [$];

    canonical_huffman_code_table_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] %s", $time, what);
    endtask

    task automatic send_beat(input logic [MODE_W-1:0] m, input int len, input int cnt,
                             input int sym, input int code);
        cht_pkg::t_in_item beat;
        int                gap;
        beat.mode   = m;
        beat.length = LEN_W'(len);
        beat.count  = CNT_W'(cnt);
        beat.symbol = SYM_W'(sym);
        beat.code   = CODE_W'(code);
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            while (gap > 0) begin
                in_valid <= 1'b0;
                gap--;
                @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(beat);
        n_accepted++;
    endtask

    task automatic lookup_beat();
        int l;
        int sym;
        int code;
        int tries;
        if ($urandom_range(0, 1) == 0) begin
            if (seen_syms.size() > 0 && $urandom_range(0, 3) != 0)
                sym = seen_syms[$urandom_range(0, seen_syms.size() - 1)];
            else
                sym = $urandom_range(0, NSYM - 1);
            send_beat(cht_pkg::MODE_ENC, $urandom_range(0, 31), $urandom_range(0, 511), sym,
                      $urandom_range(0, 65535));
        end else begin
            l     = -1;
            tries = 0;
            while (l < 0 && tries < 8) begin
                tries++;
                l = $urandom_range(0, MAX_CODE_LEN - 1);
                if (prof_count[l] == 0)
                    l = -1;
            end
            if (l < 0 || $urandom_range(0, 4) == 0) begin
                send_beat(cht_pkg::MODE_DEC, $urandom_range(0, 31), $urandom_range(0, 511),
                          $urandom_range(0, 255), $urandom_range(0, 65535));
            end else begin
                // mostly inside the length's code range, sometimes just past either end
                case ($urandom_range(0, 5))
                    0:       code = int'(prof_first[l]) - 1;
                    1:       code = int'(prof_first[l]) + prof_count[l];
                    default: code = int'(prof_first[l]) + $urandom_range(0, prof_count[l] - 1);
                endcase
                send_beat(cht_pkg::MODE_DEC, l + 1, $urandom_range(0, 511),
                          $urandom_range(0, 255), code);
            end
        end
    endtask

    // random count per length that fits the code space, sometimes overfilled
    task automatic build_profile(output int total);
        int free_codes;
        int lim;
        int last;
        int last_free;
        free_codes = 2;
        total      = 0;
        last       = -1;
        last_free  = 0;
        for (int l = 0; l < MAX_CODE_LEN; l++) begin
            prof_count[l] = 0;
            if (free_codes > 0 && total < NSYM && $urandom_range(0, 2) == 0) begin
                lim = free_codes;
                if (lim > NSYM - total)
                    lim = NSYM - total;
                if (lim > 24)
                    lim = 24;
                prof_count[l] = $urandom_range(1, lim);
                total        += prof_count[l];
                last          = l;
                last_free     = free_codes;
            end
            free_codes = (free_codes - prof_count[l]) * 2;
            if (free_codes > 4096)
                free_codes = 4096;
        end
        if (total == 0) begin
            prof_count[$urandom_range(0, MAX_CODE_LEN - 1)] = 1;
            total = 1;
        end else if (last_free < 64 && $urandom_range(0, 5) == 0) begin
            total           += last_free + 1 - prof_count[last];
            prof_count[last] = last_free + 1;
        end
    endtask

    task automatic load_profile();
        longint run;
        int     l;
        bit     down;
        run = 0;
        for (int k = 0; k < MAX_CODE_LEN; k++) begin
            prof_first[k] = run & 64'hFFFF;
            run = (run + prof_count[k]) << 1;
        end
        if ($urandom_range(0, 7) == 0)
            send_beat(cht_pkg::MODE_LOAD,
                      ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31),
                      $urandom_range(0, 511), 0, 0);
        down = 1'($urandom_range(0, 1));
        for (int k = 0; k < MAX_CODE_LEN; k++) begin
            l = down ? MAX_CODE_LEN - 1 - k : k;
            if (prof_count[l] != 0 || $urandom_range(0, 5) == 0)
                send_beat(cht_pkg::MODE_LOAD, l + 1, prof_count[l], $urandom_range(0, 255),
                          $urandom_range(0, 65535));
        end
    endtask

    task automatic add_symbols(input int n_add, input bit unique_syms);
        int sym;
        int base;
        base = $urandom_range(0, NSYM - 1);
        seen_syms.delete();
        for (int k = 0; k < n_add; k++) begin
            if (unique_syms)
                sym = (k ^ base) % NSYM;
            else if (seen_syms.size() > 0 && $urandom_range(0, 9) == 0)
                sym = seen_syms[$urandom_range(0, seen_syms.size() - 1)];
            else
                sym = $urandom_range(0, NSYM - 1);
            seen_syms = {seen_syms, sym};
            send_beat(cht_pkg::MODE_ADD, $urandom_range(0, 31), $urandom_range(0, 511), sym,
                      $urandom_range(0, 65535));
            if ($urandom_range(0, 4) == 0)
                lookup_beat();
            if ($urandom_range(0, 29) == 0)
                send_beat(cht_pkg::MODE_LOAD, $urandom_range(1, MAX_CODE_LEN),
                          $urandom_range(0, 511), 0, 0);
        end
    endtask

    task automatic clear_beat();
        send_beat(cht_pkg::MODE_CLEAR, $urandom_range(0, 31), $urandom_range(0, 511),
                  $urandom_range(0, 255), $urandom_range(0, 65535));
    endtask

    task automatic table_sequence();
        int total;
        int extra;
        clear_beat();
        build_profile(total);
        load_profile();
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        add_symbols(total + extra, 1'b0);
        repeat ($urandom_range(4, 24))
            lookup_beat();
    endtask

    // one code per length and two at the longest, ending at the all-ones code
    task automatic chain_sequence();
        clear_beat();
        for (int l = 0; l < MAX_CODE_LEN; l++)
            prof_count[l] = (l == MAX_CODE_LEN - 1) ? 2 : 1;
        load_profile();
        add_symbols(MAX_CODE_LEN + 2, 1'b0);
        send_beat(cht_pkg::MODE_DEC, MAX_CODE_LEN, 0, 0, 'hFFFF);
        send_beat(cht_pkg::MODE_DEC, MAX_CODE_LEN, 0, 0, 'hFFFE);
        repeat ($urandom_range(4, 12))
            lookup_beat();
    endtask

    // fills every symbol slot, the last add runs out of slots
    task automatic full_sequence();
        clear_beat();
        for (int l = 0; l < MAX_CODE_LEN; l++)
            prof_count[l] = 0;
        prof_count[SYMBOL_BITS - 1] = NSYM;
        prof_count[SYMBOL_BITS]     = 4;
        load_profile();
        add_symbols(NSYM + 1, 1'b1);
        repeat ($urandom_range(8, 20))
            lookup_beat();
    endtask

    task automatic noise_sequence();
        repeat ($urandom_range(4, 16))
            send_beat(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 31),
                      $urandom_range(0, 511), $urandom_range(0, 255),
                      $urandom_range(0, 65535));
    endtask

    task automatic directed_part();
        send_beat(cht_pkg::MODE_ENC, 0, 0, 0, 0);          // lookup on an empty table
        send_beat(cht_pkg::MODE_DEC, 1, 0, 0, 0);
        send_beat(3'd5, 31, 511, 255, 'hFFFF);             // unused modes
        send_beat(3'd7, 31, 511, 255, 'hFFFF);
        send_beat(cht_pkg::MODE_LOAD, 0, 3, 0, 0);         // bad lengths are ignored
        send_beat(cht_pkg::MODE_LOAD, 17, 1, 0, 0);
        send_beat(cht_pkg::MODE_LOAD, 1, 1, 0, 0);
        send_beat(cht_pkg::MODE_LOAD, 2, 0, 0, 0);
        send_beat(cht_pkg::MODE_LOAD, 3, 2, 0, 0);
        send_beat(cht_pkg::MODE_LOAD, 16, 511, 0, 0);
        send_beat(cht_pkg::MODE_ADD, 0, 0, 255, 0);
        send_beat(cht_pkg::MODE_DEC, 1, 0, 0, 0);
        send_beat(cht_pkg::MODE_DEC, 3, 0, 0, 4);          // longer than any code so far
        send_beat(cht_pkg::MODE_ADD, 0, 0, 0, 0);
        send_beat(cht_pkg::MODE_ADD, 0, 0, 0, 0);          // duplicate symbol, later code wins
        send_beat(cht_pkg::MODE_ENC, 0, 0, 0, 0);
        send_beat(cht_pkg::MODE_DEC, 3, 0, 0, 4);
        send_beat(cht_pkg::MODE_LOAD, 1, 2, 0, 0);         // counts frozen once assigning
        send_beat(cht_pkg::MODE_ADD, 0, 0, 128, 0);
        send_beat(cht_pkg::MODE_DEC, 16, 0, 0, 'hC000);
        send_beat(cht_pkg::MODE_DEC, 0, 0, 0, 0);
        send_beat(cht_pkg::MODE_CLEAR, 0, 0, 0, 0);
        send_beat(cht_pkg::MODE_LOAD, 1, 3, 0, 0);
        send_beat(cht_pkg::MODE_ADD, 0, 0, 1, 0);
        send_beat(cht_pkg::MODE_ADD, 0, 0, 2, 0);
        send_beat(cht_pkg::MODE_ADD, 0, 0, 3, 0);          // code no longer fits
        send_beat(cht_pkg::MODE_ENC, 0, 0, 3, 0);
        send_beat(cht_pkg::MODE_ADD, 0, 0, 4, 0);          // code still does not fit
    endtask

    initial begin : stimulus
        int stop_at;
        int iter;
        int pick;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_part();
        stop_at = n_accepted + RANDOM_ITEMS;
        iter    = 0;
        while (n_accepted < stop_at) begin
            pick = $urandom_range(0, 99);
            if (iter == 1 || pick < 3)
                full_sequence();
            else if (pick < 68)
                table_sequence();
            else if (pick < 80)
                chain_sequence();
            else
                noise_sequence();
            iter++;
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0 && sb.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // result side stalls in phases of random density, plus one long hold-off
    initial begin : receiver
        int  phase_left;
        int  pct;
        bit  held;
        phase_left = 0;
        pct        = 0;
        held       = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && n_accepted >= 500) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(16, 128);
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 30;
                    2:       pct = 60;
                    default: pct = 90;
                endcase
            end
            phase_left--;
            out_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    always @(posedge clk) begin : result_monitor
        string why;
        if (rst_n && out_valid && !out_stall) begin
            why = sb.check_beat(out_data);
            if (why != "")
                report_mismatch(why);
        end
    end

    initial begin : watchdog
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            n_cycles++;
        end
        $display("tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/cht_pkg.sv
design/cht_ram.sv
design/cht_ctrl.sv
design/cht_dp.sv
design/canonical_huffman_code_table_core.sv
tb/tb.sv
